[sv/aalr_pkg.sv]
// Shared types and constants for the antialiased line rasterizer.
// Holds command/status structs, state and mode encodings; no dependencies.
package aalr_pkg;

  localparam int SCREEN_SIDE_DEF = 16;
  localparam int FRAC_BITS_DEF   = 12;

  localparam int COORD_W     = 7;
  localparam int MINOR_W     = COORD_W + 2;
  localparam int COLOR_W     = 8;
  localparam int MODE_W      = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;

  localparam logic [COLOR_W-1:0] CH_LO_MASK = 8'h11;
  localparam logic [COLOR_W-1:0] CH_HI_MASK = 8'h22;

  typedef enum logic [MODE_W-1:0] {
    MODE_DRAW,
    MODE_READ,
    MODE_WRITE,
    MODE_NOP
  } mode_t;

  typedef enum logic [1:0] {
    PIX_CENTER,
    PIX_PLUS,
    PIX_MINUS
  } pix_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_DIV_WAIT,
    ST_PIX0,
    ST_PIX1,
    ST_PIX2,
    ST_PIX3,
    ST_PEEK,
    ST_POKE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic slope_ld;
    logic pix_rd;
    pix_t rd_sel;
    logic pix_wr;
    pix_t wr_sel;
    logic step;
    logic peek;
    logic poke;
    logic clr_wr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic  div_done;
    logic  last;
    logic  clr_last;
    mode_t mode;
  } stat_t;

endpackage

[sv/aalr_div.sv]
// Restoring divider for the line slope: quotient of (num << FRAC_BITS) / den.
// One quotient bit per cycle. Depends on aalr_pkg.
module aalr_div #(
  parameter int FRAC_BITS = aalr_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [aalr_pkg::COORD_W-1:0]  num,
  input  logic [aalr_pkg::COORD_W-1:0]  den,
  output logic [FRAC_BITS:0]            quo,
  output logic                          done
);

  localparam int DVD_W = aalr_pkg::COORD_W + FRAC_BITS;
  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]            dvd_r;
  logic [aalr_pkg::COORD_W-1:0] rem_r;
  logic [DVD_W-1:0]            quo_r;
  logic [CNT_W-1:0]            cnt_r;
  logic                        busy_r;
  logic                        done_r;

  logic [aalr_pkg::COORD_W:0]   trial;
  logic [aalr_pkg::COORD_W:0]   diff;
  logic                        fits;
  logic [aalr_pkg::COORD_W-1:0] rem_nxt;

  always_comb begin
    trial   = {rem_r, dvd_r[DVD_W-1]};
    diff    = trial - {1'b0, den};
    fits    = trial >= {1'b0, den};
    rem_nxt = fits ? diff[aalr_pkg::COORD_W-1:0] : trial[aalr_pkg::COORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(DVD_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= {num, {FRAC_BITS{1'b0}}};
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DVD_W-2:0], fits};
    end
  end

  assign quo  = quo_r[FRAC_BITS:0];
  assign done = done_r;

endmodule

[sv/aalr_dp.sv]
// Datapath: line setup, slope divider, error stepping, pixel blend and frame store.
// Driven by aalr_ctrl through cmd_t; depends on aalr_pkg and aalr_div.
module aalr_dp #(
  parameter int SCREEN_SIDE = aalr_pkg::SCREEN_SIDE_DEF,
  parameter int FRAC_BITS   = aalr_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  aalr_pkg::cmd_t                cmd,
  output aalr_pkg::stat_t               stat,
  input  aalr_pkg::mode_t               mode,
  input  logic [aalr_pkg::COORD_W-1:0]  start_x,
  input  logic [aalr_pkg::COORD_W-1:0]  start_y,
  input  logic [aalr_pkg::COORD_W-1:0]  end_x,
  input  logic [aalr_pkg::COORD_W-1:0]  end_y,
  input  logic [aalr_pkg::COLOR_W-1:0]  color,
  output logic [aalr_pkg::COLOR_W-1:0]  read_value
);

  localparam int CW     = aalr_pkg::COORD_W;
  localparam int MW     = aalr_pkg::MINOR_W;
  localparam int DEPTH  = SCREEN_SIDE * SCREEN_SIDE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int RC_W   = $clog2(SCREEN_SIDE);
  localparam int LV_W   = FRAC_BITS + 3;

  localparam logic signed [LV_W-1:0] ONE_L      = LV_W'(1) << FRAC_BITS;
  localparam logic signed [LV_W-1:0] HALF_L     = LV_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [LV_W-1:0] NEG_HALF_L = -HALF_L;
  localparam logic [LV_W-1:0]        HALF_M     = LV_W'(1) << (FRAC_BITS - 1);
  localparam logic [LV_W+2:0]        ONE_X      = (LV_W + 3)'(1) << FRAC_BITS;
  localparam logic [LV_W+2:0]        FOUR_X     = (LV_W + 3)'(1) << (FRAC_BITS + 2);
  localparam logic [FRAC_BITS:0]     QUO_ONE    = (FRAC_BITS + 1)'(1) << FRAC_BITS;

  typedef struct packed {
    logic                     on;
    logic [ADDR_W-1:0]        addr;
    logic signed [LV_W-1:0]   level;
  } pinfo_t;

  function automatic pinfo_t pix_at(aalr_pkg::pix_t sel, logic [CW-1:0] maj,
                                    logic signed [MW-1:0] mnr,
                                    logic signed [LV_W-1:0] err, logic xmaj);
    pinfo_t               p;
    logic signed [MW-1:0] mn;
    logic signed [MW-1:0] mj;
    logic signed [MW-1:0] col;
    logic signed [MW-1:0] row;
    unique case (sel)
      aalr_pkg::PIX_CENTER: begin
        mn      = mnr;
        p.level = err;
      end
      aalr_pkg::PIX_PLUS: begin
        mn      = mnr + MW'(1);
        p.level = err - ONE_L;
      end
      aalr_pkg::PIX_MINUS: begin
        mn      = mnr - MW'(1);
        p.level = err + ONE_L;
      end
      default: begin
        mn      = mnr;
        p.level = err;
      end
    endcase
    mj   = $signed({2'b00, maj});
    col  = xmaj ? mj : mn;
    row  = xmaj ? mn : mj;
    p.on = !col[MW-1] && (col[MW-2:0] < (MW - 1)'(SCREEN_SIDE)) &&
           !row[MW-1] && (row[MW-2:0] < (MW - 1)'(SCREEN_SIDE));
    p.addr = ADDR_W'(row[RC_W-1:0]) * ADDR_W'(SCREEN_SIDE) + ADDR_W'(col[RC_W-1:0]);
    return p;
  endfunction

  // setup of a draw beat, taken straight from the input fields
  logic signed [CW:0] dx, dy, dmaj_s, dmin_s, dmaj_n, dmin_n;
  logic [CW-1:0]      adx, ady, maj0, maj1, minor0;
  logic               xmaj, rev;

  always_comb begin
    dx     = $signed({1'b0, end_x}) - $signed({1'b0, start_x});
    dy     = $signed({1'b0, end_y}) - $signed({1'b0, start_y});
    dmaj_n = -dx;
    dmin_n = -dy;
    adx    = dx[CW] ? dmaj_n[CW-1:0] : dx[CW-1:0];
    ady    = dy[CW] ? dmin_n[CW-1:0] : dy[CW-1:0];
    xmaj   = adx >= ady;
    dmaj_s = xmaj ? dx : dy;
    dmin_s = xmaj ? dy : dx;
    rev    = dmaj_s[CW];
    maj0   = xmaj ? start_x : start_y;
    maj1   = xmaj ? end_x : end_y;
    minor0 = rev ? (xmaj ? end_y : end_x) : (xmaj ? start_y : start_x);
  end

  aalr_pkg::mode_t          mode_r;
  logic [aalr_pkg::COLOR_W-1:0] color_r;
  logic [CW-1:0]            sx_r, sy_r;
  logic [CW-1:0]            m_r, maj1_r, dmaj_r, dmin_mag_r;
  logic signed [MW-1:0]     minor_r;
  logic                     xmaj_r, neg_r;
  logic signed [LV_W-1:0]   err_r, slope_r;
  logic [ADDR_W-1:0]        clr_r;
  logic [aalr_pkg::COLOR_W-1:0] mem_q_r, out_data_r;
  logic [aalr_pkg::COLOR_W-1:0] mem [DEPTH];

  logic [FRAC_BITS:0]       quo;
  logic                     div_done;

  aalr_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (dmin_mag_r),
    .den   (dmaj_r),
    .quo   (quo),
    .done  (div_done)
  );

  // error stepping along the major axis
  logic signed [LV_W-1:0] e1, e2, err_nxt;
  logic signed [MW-1:0]   minor_nxt;

  always_comb begin
    e1        = err_r + slope_r;
    e2        = e1;
    minor_nxt = minor_r;
    if (e1 > HALF_L) begin
      e2        = e1 - ONE_L;
      minor_nxt = minor_r + MW'(1);
    end
    err_nxt = e2;
    if (e2 < NEG_HALF_L) begin
      err_nxt   = e2 + ONE_L;
      minor_nxt = minor_r - MW'(1);
    end
  end

  logic signed [LV_W-1:0] slope_mag;
  assign slope_mag = (dmaj_r == '0) ? '0 : $signed({2'b00, quo});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r <= '0;
      clr_r <= '0;
    end else begin
      if (cmd.load) begin
        err_r <= '0;
      end else if (cmd.step) begin
        err_r <= err_nxt;
      end
      if (cmd.clr_wr) begin
        clr_r <= clr_r + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r     <= mode;
      color_r    <= color;
      sx_r       <= start_x;
      sy_r       <= start_y;
      xmaj_r     <= xmaj;
      m_r        <= rev ? maj1 : maj0;
      maj1_r     <= rev ? maj0 : maj1;
      minor_r    <= $signed({2'b00, minor0});
      dmaj_r     <= xmaj ? adx : ady;
      dmin_mag_r <= xmaj ? ady : adx;
      neg_r      <= dmin_s[CW] ^ rev;
    end else if (cmd.step) begin
      m_r     <= m_r + CW'(1);
      minor_r <= minor_nxt;
    end
    if (cmd.slope_ld) begin
      slope_r <= neg_r ? -slope_mag : slope_mag;
    end
  end

  // pixel read/write ports
  pinfo_t                   rd_info, wr_info;
  logic [LV_W-1:0]          mag;
  logic [LV_W+2:0]          mag5;
  logic                     hit;
  logic [aalr_pkg::COLOR_W-1:0] blend_val;
  logic                     start_on;
  logic [ADDR_W-1:0]        start_addr;

  always_comb begin
    rd_info    = pix_at(cmd.rd_sel, m_r, minor_r, err_r, xmaj_r);
    wr_info    = pix_at(cmd.wr_sel, m_r, minor_r, err_r, xmaj_r);
    mag        = wr_info.level[LV_W-1] ? LV_W'(-wr_info.level) : LV_W'(wr_info.level);
    mag5       = {3'b000, mag} + {1'b0, mag, 2'b00};
    hit        = 1'b1;
    blend_val  = mem_q_r;
    priority if (mag5 < ONE_X) begin
      blend_val = color_r | mem_q_r;
    end else if (mag < HALF_M) begin
      blend_val = (color_r & aalr_pkg::CH_HI_MASK) | mem_q_r;
    end else if (mag5 < FOUR_X) begin
      blend_val = (color_r & aalr_pkg::CH_LO_MASK) | mem_q_r;
    end else begin
      hit = 1'b0;
    end
    start_on   = (sx_r < CW'(SCREEN_SIDE)) && (sy_r < CW'(SCREEN_SIDE));
    start_addr = ADDR_W'(sy_r[RC_W-1:0]) * ADDR_W'(SCREEN_SIDE) +
                 ADDR_W'(sx_r[RC_W-1:0]);
  end

  logic                     we, re;
  logic [ADDR_W-1:0]        waddr, raddr;
  logic [aalr_pkg::COLOR_W-1:0] wdata;

  always_comb begin
    we    = 1'b0;
    waddr = wr_info.addr;
    wdata = blend_val;
    priority if (cmd.clr_wr) begin
      we    = 1'b1;
      waddr = clr_r;
      wdata = '0;
    end else if (cmd.poke) begin
      we    = start_on;
      waddr = start_addr;
      wdata = color_r;
    end else if (cmd.pix_wr) begin
      we    = wr_info.on && hit;
    end
    re    = cmd.peek || cmd.pix_rd;
    raddr = cmd.peek ? start_addr : rd_info.addr;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      mem_q_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= (mode_r == aalr_pkg::MODE_READ && start_on) ? mem_q_r : '0;
    end
  end

  assign read_value    = out_data_r;
  assign stat.div_done = div_done;
  assign stat.last     = m_r == maj1_r;
  assign stat.clr_last = clr_r == ADDR_W'(DEPTH - 1);
  assign stat.mode     = mode_r;

  a_rw_addr_apart : assert property (@(posedge clk) disable iff (!rst_n)
    (we && re) |-> (waddr != raddr))
    else $error("frame store read and write collide on one address");

  a_err_range : assert property (@(posedge clk) disable iff (!rst_n)
    (err_r <= HALF_L) && (err_r >= NEG_HALF_L))
    else $error("line error left the half-pixel band");

  a_slope_bound : assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.slope_ld && dmaj_r != '0) |-> (quo <= QUO_ONE))
    else $error("slope magnitude above one");

endmodule

[sv/aalr_ctrl.sv]
// Controller state machine: clear pass, command dispatch, pixel pipeline, result hand-off.
// Talks to aalr_dp through cmd_t/stat_t; depends on aalr_pkg.
module aalr_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  aalr_pkg::stat_t stat,
  output aalr_pkg::cmd_t  cmd
);

  aalr_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             in_accept;

  assign in_tready  = state_r == aalr_pkg::ST_IDLE;
  assign in_accept  = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      aalr_pkg::ST_CLEAR: begin
        if (stat.clr_last) state_nxt = aalr_pkg::ST_IDLE;
      end
      aalr_pkg::ST_IDLE: begin
        if (in_accept) state_nxt = aalr_pkg::ST_DISPATCH;
      end
      aalr_pkg::ST_DISPATCH: begin
        unique case (stat.mode)
          aalr_pkg::MODE_DRAW:  state_nxt = aalr_pkg::ST_DIV_WAIT;
          aalr_pkg::MODE_READ:  state_nxt = aalr_pkg::ST_PEEK;
          aalr_pkg::MODE_WRITE: state_nxt = aalr_pkg::ST_POKE;
          aalr_pkg::MODE_NOP:   state_nxt = aalr_pkg::ST_DONE;
        endcase
      end
      aalr_pkg::ST_DIV_WAIT: begin
        if (stat.div_done) state_nxt = aalr_pkg::ST_PIX0;
      end
      aalr_pkg::ST_PIX0: state_nxt = aalr_pkg::ST_PIX1;
      aalr_pkg::ST_PIX1: state_nxt = aalr_pkg::ST_PIX2;
      aalr_pkg::ST_PIX2: state_nxt = aalr_pkg::ST_PIX3;
      aalr_pkg::ST_PIX3: begin
        state_nxt = stat.last ? aalr_pkg::ST_DONE : aalr_pkg::ST_PIX0;
      end
      aalr_pkg::ST_PEEK: state_nxt = aalr_pkg::ST_DONE;
      aalr_pkg::ST_POKE: state_nxt = aalr_pkg::ST_DONE;
      aalr_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) state_nxt = aalr_pkg::ST_IDLE;
      end
      default: state_nxt = aalr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      aalr_pkg::ST_CLEAR: cmd.clr_wr = 1'b1;
      aalr_pkg::ST_IDLE:  cmd.load = in_accept;
      aalr_pkg::ST_DISPATCH: cmd.div_start = stat.mode == aalr_pkg::MODE_DRAW;
      aalr_pkg::ST_DIV_WAIT: cmd.slope_ld = stat.div_done;
      aalr_pkg::ST_PIX0: begin
        cmd.pix_rd = 1'b1;
        cmd.rd_sel = aalr_pkg::PIX_CENTER;
      end
      aalr_pkg::ST_PIX1: begin
        cmd.pix_rd = 1'b1;
        cmd.rd_sel = aalr_pkg::PIX_PLUS;
        cmd.pix_wr = 1'b1;
        cmd.wr_sel = aalr_pkg::PIX_CENTER;
      end
      aalr_pkg::ST_PIX2: begin
        cmd.pix_rd = 1'b1;
        cmd.rd_sel = aalr_pkg::PIX_MINUS;
        cmd.pix_wr = 1'b1;
        cmd.wr_sel = aalr_pkg::PIX_PLUS;
      end
      aalr_pkg::ST_PIX3: begin
        cmd.pix_wr = 1'b1;
        cmd.wr_sel = aalr_pkg::PIX_MINUS;
        cmd.step   = 1'b1;
      end
      aalr_pkg::ST_PEEK: cmd.peek = 1'b1;
      aalr_pkg::ST_POKE: cmd.poke = 1'b1;
      aalr_pkg::ST_DONE: cmd.out_load = !out_valid_r || out_tready;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= aalr_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_dispatch : assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == aalr_pkg::ST_DISPATCH))
    else $error("accepted beat not dispatched");

  a_step_loop : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == aalr_pkg::ST_PIX3 && !stat.last) |=> (state_r == aalr_pkg::ST_PIX0))
    else $error("line walk ended before the last major step");

endmodule

[sv/antialiased_line_rasterizer.sv]
// Antialiased line rasterizer into a square byte frame store (top level).
// Joins aalr_ctrl and aalr_dp; depends on aalr_pkg.
//
// After reset the block sweeps the frame store to zero, one byte a cycle,
// across all SCREEN_SIDE*SCREEN_SIDE bytes (256 by default) with in_tready
// low. Each input beat then yields exactly one output beat. A draw beat
// first computes the slope in a divider that retires one quotient bit a
// cycle, then walks the major axis; each major step does three
// read-modify-writes through the single read and single write port of the
// frame store. A result still waiting on out_tready holds the next beat in
// its final cycle.
module antialiased_line_rasterizer #(
  parameter int SCREEN_SIDE = aalr_pkg::SCREEN_SIDE_DEF,
  parameter int FRAC_BITS   = aalr_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // start_x[6:0], start_y[13:7], end_x[20:14], end_y[27:21], color[35:28], zero pad
  input  logic [aalr_pkg::IN_TDATA_W-1:0]  in_tdata,
  // mode[1:0]
  input  logic [aalr_pkg::MODE_W-1:0]      in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // read_value[7:0]
  output logic [aalr_pkg::OUT_TDATA_W-1:0] out_tdata
);

  aalr_pkg::cmd_t  cmd;
  aalr_pkg::stat_t stat;

  aalr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  aalr_dp #(
    .SCREEN_SIDE (SCREEN_SIDE),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .mode       (aalr_pkg::mode_t'(in_tuser)),
    .start_x    (in_tdata[6:0]),
    .start_y    (in_tdata[13:7]),
    .end_x      (in_tdata[20:14]),
    .end_y      (in_tdata[27:21]),
    .color      (in_tdata[35:28]),
    .read_value (out_tdata)
  );

endmodule
